@@ design/kmp_pkg.sv @@
// ----------------------------------------------------------------------------
// kmp_pkg: shared definitions for the KMP pattern matcher
// Widths, configuration register indexes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

  // Fixed field widths
  localparam int TEXT_BITS     = 8;
  localparam int START_BITS    = 32;
  localparam int LEN_BITS      = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int PAT_WORDS     = 4;
  localparam int PAT_BYTES     = PAT_WORDS * CFG_DATA_BITS / TEXT_BITS;

  // Parameter defaults
  localparam int MAX_PATTERN_DEF   = 32;
  localparam int POSITION_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd4;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic step;   // take the presented byte
    logic clear;  // drop every partial match (wins over step)
  } kmp_cell_ctl_t;

endpackage

`default_nettype wire

@@ design/kmp_in_if.sv @@
// ----------------------------------------------------------------------------
// kmp_in_if: text byte channel
// Carries one text byte and its new-text flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmp_in_if
  import kmp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [TEXT_BITS-1:0] text_byte;
  logic                 first;

  modport source (output valid, output text_byte, output first, input ready);
  modport sink   (input valid, input text_byte, input first, output ready);
endinterface

`default_nettype wire

@@ design/kmp_out_if.sv @@
// ----------------------------------------------------------------------------
// kmp_out_if: match result channel
// Carries the text offset of one complete match per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmp_out_if
  import kmp_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [START_BITS-1:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface

`default_nettype wire

@@ design/kmp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// kmp_cfg_if: configuration write channel
// Carries a register index and its write data per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmp_cfg_if
  import kmp_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/kmp_cell.sv @@
// ----------------------------------------------------------------------------
// kmp_cell: one pattern position of the matcher chain
// Holds whether the text so far ends with the pattern prefix up to and
// including this position.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_cell
  import kmp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kmp_cell_ctl_t        ctl,
  input  wire logic                 en,        // position lies inside the pattern
  input  wire logic                 prev_act,  // shorter prefix held by neighbour
  input  wire logic [TEXT_BITS-1:0] char_in,
  input  wire logic [TEXT_BITS-1:0] pat_char,
  output logic                      act,
  output logic                      hit        // value taken on a step
);

  logic act_r;
  logic act_nxt;

  // Prefix extends by one when the neighbour held and the byte agrees
  assign hit = en & prev_act & (char_in == pat_char);

  always_comb begin
    act_nxt = act_r;
    if (ctl.clear) begin
      act_nxt = 1'b0;
    end else if (ctl.step) begin
      act_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  assign act = act_r;

endmodule

`default_nettype wire

@@ design/kmp_chain.sv @@
// ----------------------------------------------------------------------------
// kmp_chain: row of matcher cells
// Each cell hands its partial-match bit to the next one every step; the
// longest set bit is the KMP matched prefix length.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_chain
  import kmp_pkg::*;
#(
  parameter int N = MAX_PATTERN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire kmp_cell_ctl_t                  ctl,
  input  wire logic                           restart,  // new text: forget history
  input  wire logic [N-1:0]                   en,
  input  wire logic [TEXT_BITS-1:0]           char_in,
  input  wire logic [PAT_BYTES*TEXT_BITS-1:0] pat_flat,
  output logic      [N-1:0]                   act,
  output logic      [N-1:0]                   hit
);

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic prev;

    // Head cell always starts a fresh prefix; others follow the neighbour
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = act[k-1] & ~restart;
    end

    kmp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .en       (en[k]),
      .prev_act (prev),
      .char_in  (char_in),
      .pat_char (pat_flat[k*TEXT_BITS +: TEXT_BITS]),
      .act      (act[k]),
      .hit      (hit[k])
    );
  end

endmodule

`default_nettype wire

@@ design/kmp_pattern_matcher.sv @@
// Result: the byte that completes a match, once taken, puts its start offset into
//   the result queue; a byte that completes no match gives nothing.
// Throughput: one text byte per cycle while the prefix table is current and the
//   result queue has room. After a known configuration write the next byte waits
//   while the chain is emptied and replays the kept prefix (at most length - 1).
// Reset: synchronous, active low; prefix, position and result queue cleared.
// ----------------------------------------------------------------------------
// kmp_pattern_matcher: streaming KMP string search
// Text bytes run through a chain of cells, one per pattern byte; a full
// match reports its start offset and empties the chain (no overlap).
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_pattern_matcher
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kmp_in_if.sink     in_ch,
  kmp_out_if.source  out_ch,
  kmp_cfg_if.sink    cfg_ch
);

  localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PB_IDX   = $clog2(PAT_BYTES);
  localparam int PB       = POSITION_BITS;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_PREP = 3'b010,
    ST_FEED = 3'b100
  } kmp_state_t;

  // Configuration registers
  logic [LEN_BITS-1:0]      len_raw_r;
  logic [CFG_DATA_BITS-1:0] pat_word_r [PAT_WORDS];
  logic                     table_ready_r;
  logic                     table_ready_nxt;
  logic                     cfg_acc;
  logic                     cfg_known;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid & cfg_ch.ready;
  assign cfg_known    = (cfg_ch.index == REG_PATTERN_LENGTH) ||
                        (cfg_ch.index == REG_PATTERN_WORD_0) ||
                        (cfg_ch.index == REG_PATTERN_WORD_1) ||
                        (cfg_ch.index == REG_PATTERN_WORD_2) ||
                        (cfg_ch.index == REG_PATTERN_WORD_3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_raw_r <= LEN_BITS'(1);
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_PATTERN_LENGTH: len_raw_r     <= cfg_ch.data[LEN_BITS-1:0];
        REG_PATTERN_WORD_0: pat_word_r[0] <= cfg_ch.data;
        REG_PATTERN_WORD_1: pat_word_r[1] <= cfg_ch.data;
        REG_PATTERN_WORD_2: pat_word_r[2] <= cfg_ch.data;
        REG_PATTERN_WORD_3: pat_word_r[3] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic [PAT_BYTES*TEXT_BITS-1:0] pat_flat;
  assign pat_flat = {pat_word_r[3], pat_word_r[2], pat_word_r[1], pat_word_r[0]};

  // Effective length: zero reads as one, clamp at the chain size
  logic [LEN_BITS-1:0] len_eff;
  logic [LEN_BITS-1:0] len_m1;
  always_comb begin
    len_eff = len_raw_r;
    if (len_raw_r == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_raw_r > LEN_BITS'(MAX_PATTERN)) begin
      len_eff = LEN_BITS'(MAX_PATTERN);
    end
  end
  assign len_m1 = len_eff - LEN_BITS'(1);

  // Cells beyond the pattern stay idle
  logic [MAX_PATTERN-1:0] cell_en;
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cell_en[k] = (LEN_BITS'(k) < len_eff);
    end
  end

  // Sequencer state
  kmp_state_t           state_r, state_nxt;
  logic [LEN_BITS-1:0]  target_r, target_nxt;
  logic [PB_IDX-1:0]    cnt_r, cnt_nxt;
  logic [LEN_BITS-1:0]  j_old;

  // Result queue
  logic [START_BITS-1:0] q_data_r [2];
  logic                  q_wr_r, q_rd_r;
  logic [1:0]            q_cnt_r, q_cnt_nxt;
  logic                  push, pop;

  // Chain
  kmp_cell_ctl_t          cell_ctl;
  logic [MAX_PATTERN-1:0] act, hit;
  logic [TEXT_BITS-1:0]   chain_char;
  logic                   restart;
  logic                   match;
  logic                   in_acc;

  assign in_ch.ready = (state_r == ST_RUN) & table_ready_r & (q_cnt_r != 2'd2);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign match       = hit[len_m1[IDX_BITS-1:0]];
  assign restart     = in_acc & in_ch.first;
  assign chain_char  = (state_r == ST_FEED) ? pat_flat[cnt_r*TEXT_BITS +: TEXT_BITS]
                                            : in_ch.text_byte;

  // Longest partial match currently held
  always_comb begin
    j_old = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (act[k]) begin
        j_old = LEN_BITS'(k + 1);
      end
    end
  end

  // Rebuild replays the kept prefix through an emptied chain
  always_comb begin
    state_nxt       = state_r;
    target_nxt      = target_r;
    cnt_nxt         = cnt_r;
    table_ready_nxt = table_ready_r;
    cell_ctl        = '0;
    unique case (state_r)
      ST_RUN: begin
        cell_ctl.step  = in_acc;
        cell_ctl.clear = in_acc & match;
        if (!table_ready_r && in_ch.valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cell_ctl.clear = 1'b1;
        if (in_ch.first || j_old >= len_eff) begin
          target_nxt = '0;
        end else begin
          target_nxt = j_old;
        end
        cnt_nxt = '0;
        if (target_nxt == '0) begin
          table_ready_nxt = 1'b1;
          state_nxt       = ST_RUN;
        end else begin
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        cell_ctl.step = 1'b1;
        cnt_nxt       = cnt_r + PB_IDX'(1);
        if (LEN_BITS'(cnt_r) + LEN_BITS'(1) == target_r) begin
          table_ready_nxt = 1'b1;
          state_nxt       = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    if (cfg_acc && cfg_known) begin
      table_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RUN;
      table_ready_r <= 1'b0;
      target_r      <= '0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      table_ready_r <= table_ready_nxt;
      target_r      <= target_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  kmp_chain #(
    .N (MAX_PATTERN)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .restart  (restart),
    .en       (cell_en),
    .char_in  (chain_char),
    .pat_flat (pat_flat),
    .act      (act),
    .hit      (hit)
  );

  // Text position and match offset
  logic [PB-1:0] pos_r, pos_nxt, pos_use, start_pos;
  logic [63:0]   start_wide;

  assign pos_use    = in_ch.first ? '0 : pos_r;
  assign start_pos  = pos_use + PB'(1) - PB'(len_eff);
  assign start_wide = 64'(start_pos);

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      pos_nxt = pos_use + PB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Two-entry result queue lets bytes flow while a result waits
  assign push      = in_acc & match;
  assign pop       = out_ch.valid & out_ch.ready;
  assign q_cnt_nxt = q_cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[q_wr_r] <= start_wide[START_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r ^ push;
      q_rd_r  <= q_rd_r ^ pop;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  assign out_ch.valid       = (q_cnt_r != 2'd0);
  assign out_ch.match_start = q_data_r[q_rd_r];

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_cnt_r != 2'd2)
    else $error("result pushed into a full queue");

  a_feed_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FEED |-> !match)
    else $error("replay of kept prefix reached a full match");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.first) |=> pos_r == PB'(1))
    else $error("new text did not restart the position");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(table_ready_r)) |-> $past(cfg_acc && cfg_known))
    else $error("prefix table invalidated without a configuration write");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the KMP pattern matcher
// A short directed table covers reset behaviour, length clamping, the new-text
// flag, prefix handling across a pattern change and writes to spare register
// indexes. Random phases follow: each phase loads a fresh pattern from a
// small alphabet, then streams text rich in copies of it. Every result is
// checked against an internal KMP model, with random stalls on both channels
// and one long hold-off on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import kmp_pkg::*;

  localparam int RANDOM_BYTES  = 950;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;

  // Indexes past the last pattern word; writes there must be ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // Byte rows carry the text byte in data[7:0] and the new-text flag in data[8]
  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic                     typed;
    logic                     hit;
    logic [START_BITS-1:0]    start;
  } dir_row_t;

  localparam int DIR_ROWS = 31;

  // Directed stimulus; pattern "abc" is 61 62 63
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h100,                 1'b1, 1'b1, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h0ff,                 1'b1, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h000,                 1'b1, 1'b1, 32'd2},
    '{ROW_CFG,  REG_PATTERN_WORD_0, 64'h0000_0000_0063_6261, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd3,                   1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h161,                 1'b1, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h062,                 1'b1, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h063,                 1'b1, 1'b1, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h061,                 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h062,                 1'b0, 1'b0, 32'd0},
    // length 2 with junk in the upper bits: the held prefix of 2 is dropped
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC2, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h061,                 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h062,                 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h161,                 1'b0, 1'b0, 32'd0},
    // back to 3: the prefix of 1 survives the rebuild
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd3,                   1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h062,                 1'b0, 1'b0, 32'd0},
    // new text in the middle of a partial match
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h161,                 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h062,                 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h063,                 1'b0, 1'b0, 32'd0},
    // length zero acts as one
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd0,                   1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h161,                 1'b1, 1'b1, 32'd0},
    '{ROW_CFG,  REG_SPARE_5,        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG,  REG_SPARE_6,        64'h5555_5555_5555_5555, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG,  REG_SPARE_7,        64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h061,                 1'b1, 1'b1, 32'd1},
    // oversize lengths clamp to the maximum
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd40,                  1'b0, 1'b0, 32'd0},
    '{ROW_CFG,  REG_PATTERN_WORD_3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h1ff,                 1'b0, 1'b0, 32'd0},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd63,                  1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h07f,                 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE, REG_PATTERN_LENGTH, 64'h080,                 1'b0, 1'b0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  kmp_in_if  in_ch ();
  kmp_out_if out_ch ();
  kmp_cfg_if cfg_ch ();

  kmp_pattern_matcher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow of the matcher: registers, border table, prefix and position
  logic [LEN_BITS-1:0]      sh_len;
  logic [CFG_DATA_BITS-1:0] sh_word [PAT_WORDS];
  logic [LEN_BITS-1:0]      sh_prefix;
  logic [LEN_BITS-1:0]      sh_border [PAT_BYTES];
  bit                       sh_table_ok;
  logic [START_BITS-1:0]    sh_pos;

  logic [START_BITS-1:0] pending_starts [$];
  int                    mismatches  = 0;
  int                    starts_seen = 0;
  bit                    tx_burst    = 1'b0;

  task automatic flag_mismatch(string what);
    $display("tb_top: mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int unsigned live_len();
    int unsigned n;
    n = sh_len;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
    return n;
  endfunction

  function automatic logic [TEXT_BITS-1:0] pat_at(int unsigned k);
    return sh_word[(k >> 3) & 3][8 * (k & 7) +: 8];
  endfunction

  function automatic void cfg_shadow(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
    if (idx == REG_PATTERN_LENGTH) sh_len = data[LEN_BITS-1:0];
    else if (idx <= REG_PATTERN_WORD_3) sh_word[idx - REG_PATTERN_WORD_0] = data;
    else return;
    sh_table_ok = 1'b0;
  endfunction

  // Longest proper border of each pattern prefix
  function automatic void rebuild_borders(int unsigned len);
    int unsigned k;
    k = 0;
    sh_border[0] = '0;
    if (len > 1) sh_border[1] = '0;
    for (int unsigned i = 1; i + 1 < len; i++) begin
      while (k > 0 && pat_at(i) != pat_at(k)) k = sh_border[k];
      if (pat_at(i) == pat_at(k)) k++;
      sh_border[i + 1] = LEN_BITS'(k);
    end
  endfunction

  // One text byte through the matcher; returns 1 with the start on a full match
  function automatic bit kmp_advance(logic [TEXT_BITS-1:0] c, bit first,
                                     output logic [START_BITS-1:0] start);
    int unsigned len, j;
    bit hit;
    len   = live_len();
    start = '0;
    hit   = 1'b0;
    if (!sh_table_ok) begin
      rebuild_borders(len);
      sh_table_ok = 1'b1;
      if (sh_prefix >= len) sh_prefix = '0;
    end
    if (first) begin
      sh_pos    = '0;
      sh_prefix = '0;
    end
    j = sh_prefix;
    if (j >= len) j = 0;
    while (j > 0 && c != pat_at(j)) j = sh_border[j];
    if (c == pat_at(j)) j++;
    if (j == len) begin
      start = sh_pos + 1 - START_BITS'(len);
      hit   = 1'b1;
      j     = 0;
    end
    sh_prefix = LEN_BITS'(j);
    sh_pos    = sh_pos + 1;
    return hit;
  endfunction

  // Offer one text byte after a random gap; predict on acceptance
  task automatic send_text(logic [TEXT_BITS-1:0] b, bit first, bit typed, bit hit,
                           logic [START_BITS-1:0] typed_start);
    int gap;
    bit got;
    logic [START_BITS-1:0] start;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.first     <= first;
    do @(posedge clk); while (!in_ch.ready);
    got = kmp_advance(b, first, start);
    if (typed) begin
      got   = hit;
      start = typed_start;
    end
    if (got) pending_starts.insert(pending_starts.size(), start);
  endtask

  // Leaves cfg valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_shadow(idx, data);
  endtask

  // Stop offering text, wait for every outstanding match, then let it settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_starts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int sent, nlen, asz, nbytes, r, plen, cut;
    bit in_cfg;
    logic [CFG_DATA_BITS-1:0] val;
    logic [CFG_DATA_BITS-1:0] word_v [PAT_WORDS];
    logic [TEXT_BITS-1:0] alpha [3];
    logic [TEXT_BITS-1:0] text_q [$];
    logic [TEXT_BITS-1:0] pb;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.first     <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_PATTERN_LENGTH;
    cfg_ch.data     <= '0;

    sh_len      = LEN_BITS'(1);
    sh_word     = '{default: '0};
    sh_prefix   = '0;
    sh_border   = '{default: '0};
    sh_table_ok = 1'b0;
    sh_pos      = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (in_cfg) cfg_ch.valid <= 1'b0;
        in_cfg = 1'b0;
        send_text(dir_rows[i].data[7:0], dir_rows[i].data[8], dir_rows[i].typed,
                  dir_rows[i].hit, dir_rows[i].start);
      end
    end
    if (in_cfg) cfg_ch.valid <= 1'b0;

    // random phases: new pattern, then text built around it
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      drain();

      r = $urandom_range(0, 99);
      if (r < 55)      nlen = $urandom_range(1, 6);
      else if (r < 85) nlen = $urandom_range(7, 16);
      else if (r < 95) nlen = $urandom_range(17, 31);
      else             nlen = MAX_PATTERN_DEF;

      asz = $urandom_range(1, 3);
      foreach (alpha[a]) alpha[a] = TEXT_BITS'($urandom);
      for (int k = 0; k < PAT_BYTES; k++) begin
        pb = (k < nlen) ? alpha[$urandom_range(0, asz - 1)] : TEXT_BITS'($urandom);
        word_v[k / 8][8 * (k % 8) +: 8] = pb;
      end

      // length value, sometimes out of range or with junk above bit 5
      val = '0;
      if ($urandom_range(0, 3) == 0) val = {$urandom, $urandom};
      val[LEN_BITS-1:0] = LEN_BITS'(nlen);
      if (nlen == 1 && $urandom_range(0, 1) == 0) val[LEN_BITS-1:0] = '0;
      if (nlen == MAX_PATTERN_DEF && $urandom_range(0, 1) == 0)
        val[LEN_BITS-1:0] = LEN_BITS'($urandom_range(MAX_PATTERN_DEF + 1, 63));

      for (int ri = REG_PATTERN_LENGTH; ri <= REG_PATTERN_WORD_3; ri++) begin
        if (sent == 0 || $urandom_range(0, 9) < 7)
          write_reg(CFG_IDX_BITS'(ri),
                    (ri == REG_PATTERN_LENGTH) ? val : word_v[ri - REG_PATTERN_WORD_0]);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(REG_SPARE_5, REG_SPARE_7)),
                  {$urandom, $urandom});
      cfg_ch.valid <= 1'b0;

      // text: whole copies, partial prefixes, pattern bytes and some noise
      tx_burst = ($urandom_range(0, 3) == 0);
      plen     = live_len();
      nbytes   = $urandom_range(30, 70);
      text_q.delete();
      while (text_q.size() < nbytes) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          for (int k = 0; k < plen; k++) text_q.insert(text_q.size(), pat_at(k));
        end else if (r < 45) begin
          cut = $urandom_range(1, plen);
          for (int k = 0; k < cut; k++) text_q.insert(text_q.size(), pat_at(k));
        end else if (r < 88) begin
          text_q.insert(text_q.size(), pat_at($urandom_range(0, plen - 1)));
        end else begin
          text_q.insert(text_q.size(), TEXT_BITS'($urandom));
        end
      end
      foreach (text_q[k])
        send_text(text_q[k],
                  (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 39) == 0),
                  1'b0, 1'b0, '0);
      sent += text_q.size();
    end

    drain();
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // Result side: random stalls per transaction and one long hold-off
  initial begin : result_sink
    int gap, hold_left;
    bit burst;
    logic [START_BITS-1:0] want;
    gap       = 0;
    hold_left = 0;
    burst     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          starts_seen++;
          if (pending_starts.size() == 0) begin
            flag_mismatch($sformatf("unexpected match_start %0d", out_ch.match_start));
          end else begin
            want = pending_starts.pop_front();
            if (out_ch.match_start !== want)
              flag_mismatch($sformatf("match_start %0d, expected %0d",
                                      out_ch.match_start, want));
          end
          if (starts_seen % 50 == 0) burst = ($urandom_range(0, 3) == 0);
          // long hold so the matcher backs up into its input
          if (starts_seen == 40) hold_left = HOLD_CYCLES;
          gap = burst ? 0 : $urandom_range(0, 8);
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else if (gap > 0) begin
          gap--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: no transaction for %0d cycles", IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
